// ===== src/sample_min_max_mean_stddev_macros.svh =====
// Assertion macros shared by the sample statistics modules.
`ifndef SAMPLE_MIN_MAX_MEAN_STDDEV_MACROS_SVH
`define SAMPLE_MIN_MAX_MEAN_STDDEV_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication: whenever ante holds, cons holds.
`define SMMS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define SMMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SMMS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define SMMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/smms_pkg.sv =====
// Types, codes and constants of the sample statistics block.
`timescale 1ns / 1ps
package smms_pkg;

   localparam int DEF_MAX_SAMPLES = 8192;
   localparam int DEF_SAMPLE_BITS = 24;

   localparam int CMD_W     = 2;
   localparam int SAMPLE_W  = 24;
   localparam int COUNT_W   = 14;
   localparam int AVERAGE_W = 32;
   localparam int SPREAD_W  = 31;
   localparam int FRAC_BITS = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_START  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_FINISH = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [SAMPLE_W-1:0]   sample;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]    sample_count;
      logic [SAMPLE_W-1:0]   smallest;
      logic [SAMPLE_W-1:0]   largest;
      logic [AVERAGE_W-1:0]  average;
      logic [SPREAD_W-1:0]   spread;
      logic                  dropped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_N,
      ST_MUL_N,
      ST_LOAD_S,
      ST_MUL_S,
      ST_LOAD_R,
      ST_SQRT,
      ST_LOAD_A,
      ST_DIV_A,
      ST_LOAD_B,
      ST_DIV_B,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_CLEAR,
      DP_ADD,
      DP_DROP,
      DP_LOAD_N,
      DP_MUL_N,
      DP_LOAD_S,
      DP_MUL_S,
      DP_LOAD_R,
      DP_SQRT,
      DP_LOAD_A,
      DP_DIV,
      DP_LOAD_B,
      DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } dp_status_type;

endpackage

// ===== src/smms_datapath.sv =====
// Datapath: accumulators, shift-add multiplier, square root and divider.
`timescale 1ns / 1ps
`include "sample_min_max_mean_stddev_macros.svh"
module smms_datapath #(
   parameter int MAX_SAMPLES = smms_pkg::DEF_MAX_SAMPLES,
   parameter int SAMPLE_BITS = smms_pkg::DEF_SAMPLE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [smms_pkg::SAMPLE_W-1:0]   req_sample,
   input  smms_pkg::dp_cmd_type            dp_cmd,
   output smms_pkg::dp_status_type         dp_status,
   output smms_pkg::rsp_type               rsp_data
);
   import smms_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int SQS_W  = 2 * SAMPLE_BITS + CNT_W;
   localparam int SQ_W   = 2 * SAMPLE_BITS;
   localparam int DIFF_W = 2 * SUM_W;
   localparam int ROOT_W = SUM_W + FRAC_BITS;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int QUO_W  = ROOT_W;
   localparam logic [SAMPLE_W-1:0] SAMPLE_LIMIT =
      SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);

   // statistics
   logic [CNT_W-1:0]       count_ff;
   logic [SAMPLE_BITS-1:0] low_ff;
   logic [SAMPLE_BITS-1:0] high_ff;
   logic                   drop_ff;
   logic                   pend_ff;
   logic [SAMPLE_BITS-1:0] x_ff;
   logic [SQ_W-1:0]        sq_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [SQS_W-1:0]       sqs_ff;

   // finish arithmetic
   logic [DIFF_W-1:0]      acc_ff;
   logic [DIFF_W-1:0]      mcand_ff;
   logic [SUM_W-1:0]       mplier_ff;
   logic [RAD_W-1:0]       rad_ff;
   logic [ROOT_W+1:0]      rem_ff;
   logic [ROOT_W-1:0]      root_ff;
   logic [QUO_W-1:0]       dvd_ff;
   logic [CNT_W-1:0]       prem_ff;
   logic [AVERAGE_W-1:0]   avg_ff;
   rsp_type                rsp_ff;

   logic [SAMPLE_W-1:0]    sample_clamped;
   logic [SAMPLE_BITS-1:0] x_in;
   logic [SQ_W-1:0]        sq_in;
   logic [ROOT_W+1:0]      rem_sh;
   logic [ROOT_W+1:0]      trial;
   logic                   root_bit;
   logic [ROOT_W+1:0]      rem_in;
   logic [CNT_W:0]         prem_sh;
   logic                   quo_bit;
   logic [CNT_W-1:0]       prem_in;
   logic                   empty;

   assign sample_clamped = (req_sample > SAMPLE_LIMIT) ? SAMPLE_LIMIT : req_sample;
   assign x_in  = SAMPLE_BITS'(sample_clamped);
   assign sq_in = SQ_W'(x_in) * SQ_W'(x_in);
   assign empty = (count_ff == '0);

   assign dp_status.empty = empty;
   assign dp_status.full  = (count_ff == CNT_W'(MAX_SAMPLES));

   // one restoring square root step: two radicand bits in, one root bit out
   assign rem_sh   = {rem_ff[ROOT_W-1:0], rad_ff[RAD_W-1 -: 2]};
   assign trial    = {root_ff, 2'b01};
   assign root_bit = (rem_sh >= trial);
   assign rem_in   = root_bit ? (rem_sh - trial) : rem_sh;

   // one restoring division step by the sample count
   assign prem_sh = {prem_ff, dvd_ff[QUO_W-1]};
   assign quo_bit = (prem_sh >= {1'b0, count_ff});
   assign prem_in = quo_bit ? CNT_W'(prem_sh - {1'b0, count_ff}) : CNT_W'(prem_sh);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         low_ff   <= '1;
         high_ff  <= '0;
         drop_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= (dp_cmd.op == DP_ADD);
         unique case (dp_cmd.op)
            DP_CLEAR: begin
               count_ff <= '0;
               low_ff   <= '1;
               high_ff  <= '0;
               drop_ff  <= 1'b0;
            end
            DP_ADD: begin
               count_ff <= count_ff + CNT_W'(1);
               if (x_in < low_ff) begin
                  low_ff <= x_in;
               end
               if (x_in > high_ff) begin
                  high_ff <= x_in;
               end
            end
            DP_DROP: begin
               drop_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // sample and square are registered, then summed in the following cycle
   always_ff @(posedge clock) begin
      if (dp_cmd.op == DP_ADD) begin
         x_ff  <= x_in;
         sq_ff <= sq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || dp_cmd.op == DP_CLEAR) begin
         sum_ff <= '0;
         sqs_ff <= '0;
      end else if (pend_ff) begin
         sum_ff <= sum_ff + SUM_W'(x_ff);
         sqs_ff <= sqs_ff + SQS_W'(sq_ff);
      end
   end

   always_ff @(posedge clock) begin
      unique case (dp_cmd.op)
         DP_LOAD_N: begin
            acc_ff    <= '0;
            mcand_ff  <= DIFF_W'(sqs_ff);
            mplier_ff <= SUM_W'(count_ff);
         end
         DP_MUL_N: begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
         end
         DP_LOAD_S: begin
            mcand_ff  <= DIFF_W'(sum_ff);
            mplier_ff <= sum_ff;
         end
         DP_MUL_S: begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff - mcand_ff;
            end
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
         end
         DP_LOAD_R: begin
            rad_ff  <= {acc_ff, {(2 * FRAC_BITS){1'b0}}};
            rem_ff  <= '0;
            root_ff <= '0;
         end
         DP_SQRT: begin
            rad_ff  <= rad_ff << 2;
            rem_ff  <= rem_in;
            root_ff <= {root_ff[ROOT_W-2:0], root_bit};
         end
         DP_LOAD_A: begin
            dvd_ff  <= {sum_ff, {FRAC_BITS{1'b0}}};
            prem_ff <= '0;
         end
         DP_DIV: begin
            dvd_ff  <= {dvd_ff[QUO_W-2:0], quo_bit};
            prem_ff <= prem_in;
         end
         DP_LOAD_B: begin
            avg_ff  <= AVERAGE_W'(dvd_ff);
            dvd_ff  <= root_ff;
            prem_ff <= '0;
         end
         DP_RESULT: begin
            rsp_ff.sample_count <= COUNT_W'(count_ff);
            rsp_ff.dropped      <= drop_ff;
            if (empty) begin
               rsp_ff.smallest <= '0;
               rsp_ff.largest  <= '0;
               rsp_ff.average  <= '0;
               rsp_ff.spread   <= '0;
            end else begin
               rsp_ff.smallest <= SAMPLE_W'(low_ff);
               rsp_ff.largest  <= SAMPLE_W'(high_ff);
               rsp_ff.average  <= avg_ff;
               rsp_ff.spread   <= SPREAD_W'(dvd_ff);
            end
         end
         default: ;
      endcase
   end

   assign rsp_data = rsp_ff;

   `SMMS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_SAMPLES), "sample count past its limit")
   `SMMS_ASSERT_IMPL(a_marks_order, clock, reset, count_ff != '0, low_ff <= high_ff, "minimum above maximum")
   `SMMS_ASSERT_IMPL(a_sqrt_rem, clock, reset, dp_cmd.op == DP_SQRT, rem_ff <= (ROOT_W + 2)'({root_ff, 1'b0}), "root remainder too large")
   `SMMS_ASSERT_IMPL(a_div_rem, clock, reset, dp_cmd.op == DP_DIV, prem_ff < count_ff, "divider remainder not below count")

endmodule

// ===== src/smms_ctrl.sv =====
// Controller: request decoding, finish sequencing and result handshake.
`timescale 1ns / 1ps
`include "sample_min_max_mean_stddev_macros.svh"
module smms_ctrl #(
   parameter int MAX_SAMPLES = smms_pkg::DEF_MAX_SAMPLES,
   parameter int SAMPLE_BITS = smms_pkg::DEF_SAMPLE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  smms_pkg::cmd_type        req_cmd,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output smms_pkg::dp_cmd_type     dp_cmd,
   input  smms_pkg::dp_status_type  dp_status
);
   import smms_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int ROOT_W = SUM_W + FRAC_BITS;
   localparam int QUO_W  = ROOT_W;
   localparam int STEP_W = $clog2(ROOT_W);
   localparam logic [STEP_W-1:0] LAST_MUL_N = STEP_W'(CNT_W - 1);
   localparam logic [STEP_W-1:0] LAST_MUL_S = STEP_W'(SUM_W - 1);
   localparam logic [STEP_W-1:0] LAST_SQRT  = STEP_W'(ROOT_W - 1);
   localparam logic [STEP_W-1:0] LAST_DIV   = STEP_W'(QUO_W - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              collecting_ff, collecting_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_accept;
   logic              out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         collecting_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         collecting_ff <= collecting_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_cmd == CMD_FINISH) begin
               state_in = ST_LOAD_N;
            end
         end
         ST_LOAD_N: state_in = dp_status.empty ? ST_DONE : ST_MUL_N;
         ST_MUL_N:  if (step_ff == LAST_MUL_N) state_in = ST_LOAD_S;
         ST_LOAD_S: state_in = ST_MUL_S;
         ST_MUL_S:  if (step_ff == LAST_MUL_S) state_in = ST_LOAD_R;
         ST_LOAD_R: state_in = ST_SQRT;
         ST_SQRT:   if (step_ff == LAST_SQRT) state_in = ST_LOAD_A;
         ST_LOAD_A: state_in = ST_DIV_A;
         ST_DIV_A:  if (step_ff == LAST_DIV) state_in = ST_LOAD_B;
         ST_LOAD_B: state_in = ST_DIV_B;
         ST_DIV_B:  if (step_ff == LAST_DIV) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs: datapath command
   always_comb begin
      dp_cmd.op = DP_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_cmd)
                  CMD_START: dp_cmd.op = DP_CLEAR;
                  CMD_ADD: begin
                     if (collecting_ff) begin
                        dp_cmd.op = dp_status.full ? DP_DROP : DP_ADD;
                     end
                  end
                  default: dp_cmd.op = DP_IDLE;
               endcase
            end
         end
         ST_LOAD_N:          dp_cmd.op = DP_LOAD_N;
         ST_MUL_N:           dp_cmd.op = DP_MUL_N;
         ST_LOAD_S:          dp_cmd.op = DP_LOAD_S;
         ST_MUL_S:           dp_cmd.op = DP_MUL_S;
         ST_LOAD_R:          dp_cmd.op = DP_LOAD_R;
         ST_SQRT:            dp_cmd.op = DP_SQRT;
         ST_LOAD_A:          dp_cmd.op = DP_LOAD_A;
         ST_DIV_A, ST_DIV_B: dp_cmd.op = DP_DIV;
         ST_LOAD_B:          dp_cmd.op = DP_LOAD_B;
         ST_DONE:            if (out_free) dp_cmd.op = DP_RESULT;
         default:            dp_cmd.op = DP_IDLE;
      endcase
   end

   // outputs: step counter, collection window, result valid
   always_comb begin
      unique case (state_ff)
         ST_MUL_N, ST_MUL_S, ST_SQRT, ST_DIV_A, ST_DIV_B: step_in = step_ff + STEP_W'(1);
         default: step_in = '0;
      endcase

      collecting_in = collecting_ff;
      if (req_accept && req_cmd == CMD_START) begin
         collecting_in = 1'b1;
      end else if (req_accept && req_cmd == CMD_FINISH) begin
         collecting_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.op == DP_RESULT) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   `SMMS_ASSERT_IMPL(a_result_free, clock, reset, dp_cmd.op == DP_RESULT, !rsp_valid_ff || !rsp_stall, "result written over a waiting one")
   `SMMS_ASSERT_NEXT(a_finish_closes, clock, reset, req_accept && req_cmd == CMD_FINISH, !collecting_ff && state_ff == ST_LOAD_N, "finish did not close the window")
   `SMMS_ASSERT_NEXT(a_result_shown, clock, reset, dp_cmd.op == DP_RESULT, rsp_valid_ff && state_ff == ST_IDLE, "result not presented after load")

endmodule

// ===== src/sample_min_max_mean_stddev.sv =====
// Start, add and unused requests are accepted back to back.
// Finish stalls the request side while bit-serial multiplies, a square root and two
// restoring divides run on one sequencer; a finish with no samples skips the arithmetic.
// The result is registered and leaves the cycle after the sequencer writes it out.
// Synchronous active-high reset clears the statistics and closes the collection window.
`timescale 1ns / 1ps
module sample_min_max_mean_stddev #(
   parameter int MAX_SAMPLES = smms_pkg::DEF_MAX_SAMPLES,
   parameter int SAMPLE_BITS = smms_pkg::DEF_SAMPLE_BITS
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  smms_pkg::req_type   req_data,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output smms_pkg::rsp_type   rsp_data
);
   import smms_pkg::*;

   // Command and status between sequencer and datapath
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencer: decode each request, run the finish arithmetic step by step,
   // hold the result valid until the consumer takes it.
   smms_ctrl #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_data.cmd),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

   // Datapath: clamp each sample, keep count, minimum, maximum, running sum and
   // sum of squares; at finish form n*sumsq - sum^2 by shift and add, take its
   // square root with 8 extra fraction bits, then divide sum and root by n.
   smms_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_sample (req_data.sample),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .rsp_data   (rsp_data)
   );

endmodule
